[sv/pket_pkg.sv]
// Shared types, constants and helper functions of the pointer and key event tracker.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package pket_pkg;

  // Pointer position width; the position saturates to this signed range.
  localparam int POS_BITS = 16;
  // An accelerated relative delta is at most four times a 16-bit value.
  localparam int DELTA_W  = 18;
  localparam int SUM_W    = ((POS_BITS > DELTA_W) ? POS_BITS : DELTA_W) + 1;
  localparam int EXT_W    = (POS_BITS > 16) ? POS_BITS : 16;
  localparam int SCREEN_W = 15;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;

  typedef logic signed [POS_BITS-1:0] pos_t;
  typedef logic signed [DELTA_W-1:0]  delta_t;
  typedef logic [SCREEN_W-1:0]        screen_t;

  localparam screen_t RST_WIDTH  = 15'd1024;
  localparam screen_t RST_HEIGHT = 15'd768;
  localparam pos_t    RST_POS_X  = pos_t'(RST_WIDTH / 2);
  localparam pos_t    RST_POS_Y  = pos_t'(RST_HEIGHT / 2);

  // Configuration register indexes.
  localparam logic CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic CFG_SCREEN_HEIGHT = 1'b1;

  // Input item kinds.
  localparam logic [2:0] KIND_REL_X  = 3'd0;
  localparam logic [2:0] KIND_REL_Y  = 3'd1;
  localparam logic [2:0] KIND_BUTTON = 3'd2;
  localparam logic [2:0] KIND_PACKET = 3'd3;
  localparam logic [2:0] KIND_KEY    = 3'd4;
  localparam logic [2:0] KIND_SYNC   = 3'd5;

  // Result event types.
  localparam logic [2:0] EV_BTN_PRESS   = 3'd0;
  localparam logic [2:0] EV_BTN_RELEASE = 3'd1;
  localparam logic [2:0] EV_MOTION      = 3'd2;
  localparam logic [2:0] EV_KEY_PRESS   = 3'd3;
  localparam logic [2:0] EV_KEY_RELEASE = 3'd4;

  // Button numbers reported in the detail field.
  localparam logic [7:0] DET_NONE   = 8'd0;
  localparam logic [7:0] DET_LEFT   = 8'd1;
  localparam logic [7:0] DET_MIDDLE = 8'd2;
  localparam logic [7:0] DET_RIGHT  = 8'd3;

  // Evdev codes.
  localparam logic [9:0] CODE_BTN_LEFT   = 10'd272;
  localparam logic [9:0] CODE_BTN_RIGHT  = 10'd273;
  localparam logic [9:0] CODE_BTN_MIDDLE = 10'd274;
  localparam logic [9:0] CODE_KEY_LSHIFT = 10'd42;
  localparam logic [9:0] CODE_KEY_RSHIFT = 10'd54;
  localparam logic [9:0] CODE_KEY_CAPS   = 10'd58;
  localparam logic [9:0] CODE_KEY_LCTRL  = 10'd29;
  localparam logic [9:0] CODE_KEY_RCTRL  = 10'd97;
  localparam logic [9:0] CODE_KEY_LALT   = 10'd56;
  localparam logic [9:0] CODE_KEY_RALT   = 10'd100;
  localparam logic [9:0] KEYCODE_OFFSET  = 10'd8;

  // Acceleration thresholds on the delta magnitude.
  localparam logic signed [16:0] ACC_X4_ABOVE = 17'sd12;
  localparam logic signed [16:0] ACC_X3_ABOVE = 17'sd4;
  localparam logic signed [16:0] ACC_X2_ABOVE = 17'sd1;

  typedef enum logic [2:0] {
    OP_REL_X,
    OP_REL_Y,
    OP_BUTTON,
    OP_PACKET,
    OP_KEY,
    OP_SYNC
  } cmd_op_t;

  typedef enum logic [2:0] {
    MOD_NONE,
    MOD_SHIFT,
    MOD_CAPS,
    MOD_CTRL,
    MOD_ALT
  } mod_t;

  // One classified item on its way from the front end to the back end.
  typedef struct packed {
    cmd_op_t     op;
    delta_t      delta_a;  // accelerated delta, or packet x delta
    logic [15:0] delta_b;  // packet y delta
    logic        moved;    // packet carries a nonzero delta
    logic [2:0]  buttons;
    logic [7:0]  detail;
    logic        pressed;
    mod_t        modifier;
  } cmd_t;

  function automatic pos_t sat_add(pos_t p, delta_t d);
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    s  = SUM_W'(p) + SUM_W'(d);
    hi = (SUM_W'(1) <<< (POS_BITS - 1)) - SUM_W'(1);
    lo = ~hi;
    if (s > hi) begin
      s = hi;
    end
    if (s < lo) begin
      s = lo;
    end
    return pos_t'(s);
  endfunction

  // Clamp to [0, lim-1]; a zero limit yields -1 after the low clamp.
  function automatic pos_t clamp_pos(pos_t p, screen_t lim);
    logic signed [SUM_W-1:0] v;
    logic signed [SUM_W-1:0] l;
    v = SUM_W'(p);
    l = '0;
    l[SCREEN_W-1:0] = lim;
    if (v < 0) begin
      v = '0;
    end
    if (v >= l) begin
      v = l - SUM_W'(1);
    end
    return pos_t'(v);
  endfunction

  function automatic logic [15:0] pos_out(pos_t p);
    logic signed [EXT_W-1:0] e;
    e = EXT_W'(p);
    return e[15:0];
  endfunction

endpackage

`default_nettype wire

[sv/pointer_key_event_tracker.sv]
// Top level of the pointer and key event tracker: front end, command queue, back end.
// Depends on pket_pkg, pket_front, pket_fifo and pket_back.
`default_nettype none

// Turns relative motion, button, raw packet, key and batch-end beats into pointer
// and key events. An input beat is classified and queued in the same cycle it is
// taken; the back end then handles it, and a raw packet reports its changed buttons
// (up to three) one per cycle. A beat is accepted every cycle as long as the
// two-entry queue has room, so the sustained rate is one item per cycle while the
// back end does not stall and no packet changes more than one button, down to one
// result per cycle when every item produces events. The back end stalls only while
// an event waits in the output register. Screen size writes take effect on the
// next cycle; the pointer starts at the center of the reset screen size (512, 384).
module pointer_key_event_tracker (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic                              cfg_addr,
  input  wire logic [pket_pkg::SCREEN_W-1:0]     cfg_wdata,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // delta_x[15:0], delta_y[31:16], packet_buttons[34:32], event_code[44:35],
  // is_pressed[45], zero[47:46]
  input  wire logic [pket_pkg::IN_DATA_W-1:0]    in_tdata,
  // kind[2:0]
  input  wire logic [2:0]                        in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // detail[7:0], root_x[23:8], root_y[39:24], event_state[55:40]
  output logic [pket_pkg::OUT_DATA_W-1:0]        out_tdata,
  // event_type[2:0]
  output logic [2:0]                             out_tuser,
  output logic                                   out_tlast
);
  import pket_pkg::*;

  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  pket_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  pket_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  pket_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

[sv/pket_front.sv]
// Front end of the event tracker: decodes an input beat, accelerates relative motion
// and hands a classified command to the queue. Depends on pket_pkg.
`default_nettype none

module pket_front (
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [pket_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic [2:0]                     in_tuser,
  input  wire logic                           q_full,
  output logic                                q_push,
  output pket_pkg::cmd_t                      q_cmd
);
  import pket_pkg::*;

  logic signed [15:0] dx;
  logic signed [15:0] dy;
  logic [2:0]         pb;
  logic [9:0]         code;
  logic               pressed;
  logic signed [16:0] dx_wide;
  logic signed [16:0] dx_mag;
  delta_t             dx_ext;
  delta_t             dx_acc;
  logic [9:0]         keycode;
  logic               keep;

  assign dx      = in_tdata[15:0];
  assign dy      = in_tdata[31:16];
  assign pb      = in_tdata[34:32];
  assign code    = in_tdata[44:35];
  assign pressed = in_tdata[45];

  assign in_tready = !q_full;

  assign dx_wide = 17'(dx);
  assign dx_mag  = dx_wide[16] ? -dx_wide : dx_wide;
  assign dx_ext  = DELTA_W'(dx);
  assign keycode = code + KEYCODE_OFFSET;

  always_comb begin
    if (dx_mag > ACC_X4_ABOVE) begin
      dx_acc = dx_ext <<< 2;
    end else if (dx_mag > ACC_X3_ABOVE) begin
      dx_acc = (dx_ext <<< 1) + dx_ext;
    end else if (dx_mag > ACC_X2_ABOVE) begin
      dx_acc = dx_ext <<< 1;
    end else begin
      dx_acc = dx_ext;
    end
  end

  always_comb begin
    q_cmd          = '0;
    q_cmd.delta_b  = dy;
    q_cmd.buttons  = pb;
    q_cmd.pressed  = pressed;
    q_cmd.moved    = (dx != 16'sd0) || (dy != 16'sd0);
    q_cmd.modifier = MOD_NONE;
    q_cmd.detail   = DET_NONE;
    q_cmd.delta_a  = dx_acc;
    q_cmd.op       = OP_SYNC;
    keep           = 1'b1;
    unique case (in_tuser)
      KIND_REL_X: begin
        q_cmd.op = OP_REL_X;
      end
      KIND_REL_Y: begin
        q_cmd.op = OP_REL_Y;
      end
      KIND_BUTTON: begin
        q_cmd.op = OP_BUTTON;
        unique case (code)
          CODE_BTN_LEFT:   q_cmd.detail = DET_LEFT;
          CODE_BTN_RIGHT:  q_cmd.detail = DET_RIGHT;
          CODE_BTN_MIDDLE: q_cmd.detail = DET_MIDDLE;
          default:         q_cmd.detail = DET_NONE;
        endcase
        // Other button codes change nothing and produce nothing.
        keep = (q_cmd.detail != DET_NONE);
      end
      KIND_PACKET: begin
        q_cmd.op      = OP_PACKET;
        q_cmd.delta_a = dx_ext;
      end
      KIND_KEY: begin
        q_cmd.op     = OP_KEY;
        q_cmd.detail = keycode[7:0];
        unique case (code) inside
          CODE_KEY_LSHIFT, CODE_KEY_RSHIFT: q_cmd.modifier = MOD_SHIFT;
          CODE_KEY_CAPS:                    q_cmd.modifier = MOD_CAPS;
          CODE_KEY_LCTRL, CODE_KEY_RCTRL:   q_cmd.modifier = MOD_CTRL;
          CODE_KEY_LALT, CODE_KEY_RALT:     q_cmd.modifier = MOD_ALT;
          default:                          q_cmd.modifier = MOD_NONE;
        endcase
      end
      KIND_SYNC: begin
        q_cmd.op = OP_SYNC;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push = in_tvalid && in_tready && keep;

endmodule

`default_nettype wire

[sv/pket_fifo.sv]
// Two-entry command queue between the front and back ends of the event tracker.
// Depends on pket_pkg for the command type.
`default_nettype none

module pket_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire pket_pkg::cmd_t push_cmd,
  output logic                full,
  output logic                head_valid,
  output pket_pkg::cmd_t      head_cmd,
  input  wire logic           pop
);
  import pket_pkg::*;

  cmd_t       entry_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       do_pop;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_cmd   = entry_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + 2'(push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

[sv/pket_back.sv]
// Back end of the event tracker: holds pointer, button and modifier state, the screen
// size registers and the output beat register. Depends on pket_pkg.
`default_nettype none

module pket_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic                            cfg_addr,
  input  wire logic [pket_pkg::SCREEN_W-1:0]   cfg_wdata,
  input  wire logic                            head_valid,
  input  wire pket_pkg::cmd_t                  head_cmd,
  output logic                                 pop,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [pket_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [2:0]                           out_tuser,
  output logic                                 out_tlast
);
  import pket_pkg::*;

  screen_t     width_r;
  screen_t     height_r;
  pos_t        pos_x_r;
  pos_t        pos_x_nxt;
  pos_t        pos_y_r;
  pos_t        pos_y_nxt;
  logic [2:0]  mask_r;      // bit0 left, bit1 middle, bit2 right
  logic [2:0]  mask_nxt;
  logic        moved_r;
  logic        moved_nxt;
  logic        shift_r;
  logic        shift_nxt;
  logic        caps_r;
  logic        caps_nxt;
  logic        ctrl_r;
  logic        ctrl_nxt;
  logic        alt_r;
  logic        alt_nxt;
  logic        pkt_busy_r;
  logic        pkt_busy_nxt;

  logic        out_valid_r;
  logic [2:0]  out_type_r;
  logic [7:0]  out_detail_r;
  logic [15:0] out_x_r;
  logic [15:0] out_y_r;
  logic [15:0] out_state_r;
  logic        out_last_r;

  logic [2:0]  chg;
  logic [1:0]  chg_count;
  logic        needs_emit;
  logic        out_free;
  logic        fire;
  logic [2:0]  ev_type;
  logic [7:0]  ev_detail;
  logic [15:0] ev_state;
  logic        ev_last;
  logic        done;

  // Changed packet buttons in report order: left, right, middle.
  assign chg = {head_cmd.buttons[2] ^ mask_r[1],
                head_cmd.buttons[1] ^ mask_r[2],
                head_cmd.buttons[0] ^ mask_r[0]};
  assign chg_count = 2'($countones(chg));

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    case (head_cmd.op)
      OP_BUTTON: needs_emit = 1'b1;
      OP_PACKET: needs_emit = (chg != 3'b000);
      OP_KEY:    needs_emit = 1'b1;
      OP_SYNC:   needs_emit = moved_r;
      default:   needs_emit = 1'b0;
    endcase
  end

  assign fire = head_valid && (out_free || !needs_emit);

  always_comb begin
    pos_x_nxt    = pos_x_r;
    pos_y_nxt    = pos_y_r;
    mask_nxt     = mask_r;
    moved_nxt    = moved_r;
    shift_nxt    = shift_r;
    caps_nxt     = caps_r;
    ctrl_nxt     = ctrl_r;
    alt_nxt      = alt_r;
    pkt_busy_nxt = pkt_busy_r;
    ev_type      = EV_MOTION;
    ev_detail    = DET_NONE;
    ev_state     = {5'd0, mask_r, 8'd0};
    ev_last      = 1'b1;
    done         = 1'b1;
    if (fire) begin
      case (head_cmd.op)
        OP_REL_X: begin
          pos_x_nxt = sat_add(pos_x_r, head_cmd.delta_a);
          moved_nxt = 1'b1;
        end
        OP_REL_Y: begin
          pos_y_nxt = sat_add(pos_y_r, head_cmd.delta_a);
          moved_nxt = 1'b1;
        end
        OP_BUTTON: begin
          ev_type   = head_cmd.pressed ? EV_BTN_PRESS : EV_BTN_RELEASE;
          ev_detail = head_cmd.detail;
        end
        OP_PACKET: begin
          // The packet's motion lands on its first cycle, with the first changed button;
          // one changed button is reported per cycle while the output register is free.
          if (!pkt_busy_r && head_cmd.moved) begin
            pos_x_nxt = sat_add(pos_x_r, head_cmd.delta_a);
            pos_y_nxt = sat_add(pos_y_r, DELTA_W'($signed(head_cmd.delta_b)));
            moved_nxt = 1'b1;
          end
          if (chg[0]) begin
            mask_nxt[0] = head_cmd.buttons[0];
            ev_type     = head_cmd.buttons[0] ? EV_BTN_PRESS : EV_BTN_RELEASE;
            ev_detail   = DET_LEFT;
          end else if (chg[1]) begin
            mask_nxt[2] = head_cmd.buttons[1];
            ev_type     = head_cmd.buttons[1] ? EV_BTN_PRESS : EV_BTN_RELEASE;
            ev_detail   = DET_RIGHT;
          end else begin
            mask_nxt[1] = head_cmd.buttons[2];
            ev_type     = head_cmd.buttons[2] ? EV_BTN_PRESS : EV_BTN_RELEASE;
            ev_detail   = DET_MIDDLE;
          end
          ev_state     = {5'd0, mask_nxt, 8'd0};
          ev_last      = (chg_count == 2'd1);
          done         = (chg_count <= 2'd1);
          pkt_busy_nxt = !done;
        end
        OP_KEY: begin
          case (head_cmd.modifier)
            MOD_SHIFT: shift_nxt = head_cmd.pressed;
            MOD_CAPS:  caps_nxt  = caps_r ^ head_cmd.pressed;
            MOD_CTRL:  ctrl_nxt  = head_cmd.pressed;
            MOD_ALT:   alt_nxt   = head_cmd.pressed;
            default:   ;
          endcase
          ev_type   = head_cmd.pressed ? EV_KEY_PRESS : EV_KEY_RELEASE;
          ev_detail = head_cmd.detail;
          ev_state  = {12'd0, alt_nxt, ctrl_nxt, caps_nxt, shift_nxt};
        end
        OP_SYNC: begin
          pos_x_nxt = clamp_pos(pos_x_r, width_r);
          pos_y_nxt = clamp_pos(pos_y_r, height_r);
          moved_nxt = 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign pop = fire && done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= RST_WIDTH;
      height_r   <= RST_HEIGHT;
      pos_x_r    <= RST_POS_X;
      pos_y_r    <= RST_POS_Y;
      mask_r     <= 3'b000;
      moved_r    <= 1'b0;
      shift_r    <= 1'b0;
      caps_r     <= 1'b0;
      ctrl_r     <= 1'b0;
      alt_r      <= 1'b0;
      pkt_busy_r <= 1'b0;
    end else begin
      if (cfg_wr_en && (cfg_addr == CFG_SCREEN_WIDTH)) begin
        width_r <= cfg_wdata;
      end
      if (cfg_wr_en && (cfg_addr == CFG_SCREEN_HEIGHT)) begin
        height_r <= cfg_wdata;
      end
      pos_x_r    <= pos_x_nxt;
      pos_y_r    <= pos_y_nxt;
      mask_r     <= mask_nxt;
      moved_r    <= moved_nxt;
      shift_r    <= shift_nxt;
      caps_r     <= caps_nxt;
      ctrl_r     <= ctrl_nxt;
      alt_r      <= alt_nxt;
      pkt_busy_r <= pkt_busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && needs_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && needs_emit) begin
      out_type_r   <= ev_type;
      out_detail_r <= ev_detail;
      out_x_r      <= pos_out(pos_x_nxt);
      out_y_r      <= pos_out(pos_y_nxt);
      out_state_r  <= ev_state;
      out_last_r   <= ev_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_type_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {out_state_r, out_y_r, out_x_r, out_detail_r};

endmodule

`default_nettype wire
